// ----- hdl/psfp_pkg.sv -----
// Package for the particulate sensor frame parser: constants, command type.
`timescale 1ns / 1ps
`default_nettype none
package psfp_pkg;

  localparam int BUF_BYTES = 64;
  localparam int POS_W     = $clog2(BUF_BYTES);
  localparam int TOT_W     = $clog2(BUF_BYTES + 1);

  localparam logic [7:0] HDR_FIRST  = 8'h42;
  localparam logic [7:0] HDR_SECOND = 8'h4D;
  localparam int         LEN_SHIFT  = 8;
  localparam int         MIN_TOTAL  = 4 + 12 + 2;
  localparam int         OFS_PM1    = 4 + 6;
  localparam int         OFS_PM25   = 4 + 8;
  localparam int         OFS_PM10   = 4 + 10;
  localparam int         HDR_LEN    = 4;

  typedef enum logic [2:0] {
    CAP_NONE,
    CAP_PM1_HI,
    CAP_PM1_LO,
    CAP_PM25_HI,
    CAP_PM25_LO,
    CAP_PM10_HI,
    CAP_PM10_LO
  } cap_t;

  // One classified byte as passed from the front to the back.
  typedef struct packed {
    logic       start;
    logic       add;
    logic       chk_hi;
    logic       last;
    logic       long_ok;
    cap_t       cap;
    logic [7:0] data;
  } cmd_t;

endpackage
`default_nettype wire

// ----- hdl/psfp_front.sv -----
// Front of the parser: byte position tracking, length check, byte classification.
`timescale 1ns / 1ps
`default_nettype none
module psfp_front
  import psfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  input  wire logic       q_full,
  output logic            push,
  output cmd_t            cmd
);

  logic [POS_W-1:0] pos, pos_next;
  logic [TOT_W-1:0] total, total_next;
  logic [7:0]       len_hi, len_hi_next;
  logic             emit;
  logic             accept;
  logic [15:0]      len;
  logic [TOT_W:0]   pos_p2;
  logic [TOT_W:0]   tot_x;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept && emit;

  always_comb begin
    cmd         = '0;
    cmd.cap     = CAP_NONE;
    cmd.data    = rx_byte;
    emit        = 1'b0;
    pos_next    = pos;
    total_next  = total;
    len_hi_next = len_hi;
    len         = {len_hi, rx_byte};
    pos_p2      = (TOT_W+1)'(pos) + (TOT_W+1)'(2);
    tot_x       = (TOT_W+1)'(total);
    if (pos == POS_W'(0)) begin
      if (rx_byte == HDR_FIRST) begin
        emit      = 1'b1;
        cmd.start = 1'b1;
        pos_next  = POS_W'(1);
      end
    end else if (pos == POS_W'(1)) begin
      // drop back to the hunt without rechecking this byte
      if (rx_byte == HDR_SECOND) begin
        emit     = 1'b1;
        cmd.add  = 1'b1;
        pos_next = POS_W'(2);
      end else begin
        pos_next = '0;
      end
    end else if (pos == POS_W'(2)) begin
      len_hi_next = rx_byte;
      emit        = 1'b1;
      cmd.add     = 1'b1;
      pos_next    = POS_W'(3);
    end else if (pos == POS_W'(3)) begin
      if (len == 16'd0 || len > 16'(BUF_BYTES - HDR_LEN)) begin
        pos_next = '0;
      end else begin
        emit       = 1'b1;
        cmd.add    = 1'b1;
        total_next = TOT_W'(len + 16'(HDR_LEN));
        pos_next   = POS_W'(HDR_LEN);
      end
    end else begin
      emit        = 1'b1;
      cmd.add     = pos_p2 < tot_x;
      cmd.chk_hi  = pos_p2 == tot_x;
      cmd.last    = pos_p2 > tot_x;
      cmd.long_ok = total >= TOT_W'(MIN_TOTAL);
      if (pos == POS_W'(OFS_PM1))        cmd.cap = CAP_PM1_HI;
      else if (pos == POS_W'(OFS_PM1 + 1))  cmd.cap = CAP_PM1_LO;
      else if (pos == POS_W'(OFS_PM25))     cmd.cap = CAP_PM25_HI;
      else if (pos == POS_W'(OFS_PM25 + 1)) cmd.cap = CAP_PM25_LO;
      else if (pos == POS_W'(OFS_PM10))     cmd.cap = CAP_PM10_HI;
      else if (pos == POS_W'(OFS_PM10 + 1)) cmd.cap = CAP_PM10_LO;
      pos_next = cmd.last ? '0 : pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      total  <= '0;
      len_hi <= '0;
    end else if (accept) begin
      pos    <= pos_next;
      total  <= total_next;
      len_hi <= len_hi_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/psfp_queue.sv -----
// Two-entry command queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module psfp_queue
  import psfp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      full,
  output logic      q_valid,
  input  wire logic pop,
  output cmd_t      head
);

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = count == 2'd2;
  assign q_valid = count != 2'd0;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/psfp_back.sv -----
// Back of the parser: running sum, value capture, checksum test, output register.
`timescale 1ns / 1ps
`default_nettype none
module psfp_back
  import psfp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   q_valid,
  input  cmd_t        head,
  output logic        pop,
  output logic        out_valid,
  input  wire logic   out_stall,
  output logic [15:0] pm1_value,
  output logic [15:0] pm25_value,
  output logic [15:0] pm10_value
);

  logic [15:0] running_sum;
  logic [7:0]  checksum_high_byte;
  logic [15:0] captured_pm1;
  logic [15:0] captured_pm25;
  logic [15:0] captured_pm10;
  logic [15:0] chk;
  logic        good;

  // hold a final byte while an earlier result still waits
  assign pop  = q_valid && (!head.last || !out_valid || !out_stall);
  assign chk  = {checksum_high_byte, head.data};
  assign good = head.last && head.long_ok && chk == running_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum        <= '0;
      checksum_high_byte <= '0;
      captured_pm1       <= '0;
      captured_pm25      <= '0;
      captured_pm10      <= '0;
    end else if (pop) begin
      if (head.start)     running_sum <= 16'(head.data);
      else if (head.add)  running_sum <= running_sum + 16'(head.data);
      if (head.chk_hi)    checksum_high_byte <= head.data;
      case (head.cap)
        CAP_PM1_HI:  captured_pm1  <= 16'(head.data) << LEN_SHIFT;
        CAP_PM1_LO:  captured_pm1  <= captured_pm1 | 16'(head.data);
        CAP_PM25_HI: captured_pm25 <= 16'(head.data) << LEN_SHIFT;
        CAP_PM25_LO: captured_pm25 <= captured_pm25 | 16'(head.data);
        CAP_PM10_HI: captured_pm10 <= 16'(head.data) << LEN_SHIFT;
        CAP_PM10_LO: captured_pm10 <= captured_pm10 | 16'(head.data);
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && good) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && good) begin
      pm1_value  <= captured_pm1;
      pm25_value <= captured_pm25;
      pm10_value <= captured_pm10;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/particulate_sensor_frame_parser.sv -----
// Result path: a frame's last byte goes via the queue to the output register.
// Throughput: one byte per cycle unless out_stall holds a result; the front takes
// a byte whenever the two-entry queue has room, the back drains one entry per cycle.
// Reset: synchronous, active high; clears the parser to header hunt, empties the
// queue and the output register, zeroes the running sum and captured values.
// Top level of the particulate sensor frame parser.
`timescale 1ns / 1ps
`default_nettype none
module particulate_sensor_frame_parser
  import psfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [15:0]     pm1_value,
  output logic [15:0]     pm25_value,
  output logic [15:0]     pm10_value
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  logic pop;
  cmd_t head;

  psfp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  psfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .pop      (pop),
    .head     (head)
  );

  psfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pm1_value  (pm1_value),
    .pm25_value (pm25_value),
    .pm10_value (pm10_value)
  );

endmodule
`default_nettype wire
